[rtl/rodrigues_vector_rotation_macros.svh]
// assertion macros for the rotation block
`ifndef RODRIGUES_VECTOR_ROTATION_MACROS_SVH
`define RODRIGUES_VECTOR_ROTATION_MACROS_SVH
`ifndef SYNTHESIS
`define RVR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RVR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RVR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RVR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/rvr_pkg.sv]
package rvr_pkg;

   localparam int COMP_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int XY_W = 34;
   localparam int Z_W = 26;
   localparam int CS_W = 18;
   localparam int MAG_W = 30;
   localparam int SQ_W = 62;
   localparam int ROOT_W = 31;
   localparam int QUO_W = 15;
   localparam int FRAC_SHIFT = 14;
   localparam int HALF_LSB = 8192;
   localparam int UNITY = 65536;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0] neg;
      logic zero;
   } norm_type;

   function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0: val = Z_W'(2097152);
         1: val = Z_W'(1238021);
         2: val = Z_W'(654136);
         3: val = Z_W'(332050);
         4: val = Z_W'(166669);
         5: val = Z_W'(83416);
         6: val = Z_W'(41718);
         7: val = Z_W'(20860);
         8: val = Z_W'(10430);
         9: val = Z_W'(5215);
         10: val = Z_W'(2608);
         11: val = Z_W'(1304);
         12: val = Z_W'(652);
         13: val = Z_W'(326);
         14: val = Z_W'(163);
         15: val = Z_W'(81);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/rvr_cordic.sv]
module rvr_cordic #(
   parameter int COMP_BITS = rvr_pkg::COMP_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [2:0][COMP_BITS-1:0] vec_in,
   input  logic [2:0][COMP_BITS-1:0] axis_in,
   input  logic [15:0] angle_in,
   output logic out_valid,
   output logic [2:0][COMP_BITS-1:0] vec_out,
   output logic [2:0][COMP_BITS-1:0] axis_out,
   output logic signed [rvr_pkg::CS_W-1:0] cos_out,
   output logic signed [rvr_pkg::CS_W-1:0] sin_out
);
   localparam int N = rvr_pkg::CORDIC_STEPS;
   localparam int XW = rvr_pkg::XY_W;
   localparam int ZW = rvr_pkg::Z_W;
   localparam int CW = rvr_pkg::CS_W;

   logic signed [XW-1:0] x_ff [0:N];
   logic signed [XW-1:0] y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   rvr_pkg::quad_type q_ff [0:N];
   logic [2:0][COMP_BITS-1:0] vec_ff [0:N];
   logic [2:0][COMP_BITS-1:0] axis_ff [0:N];
   logic [N+1:0] vld_ff;

   logic signed [XW-1:0] xr, yr;
   logic signed [CW-1:0] cc, ss, c_in, s_in;
   logic signed [CW-1:0] c_ff, s_ff;
   logic [2:0][COMP_BITS-1:0] vec_o_ff, axis_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= rvr_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= ZW'({angle_in[13:0], 8'b0});
         q_ff[0] <= rvr_pkg::quad_type'(angle_in[15:14]);
         vec_ff[0] <= vec_in;
         axis_ff[0] <= axis_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_iter
      logic signed [XW-1:0] dx, dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[k][ZW-1]) begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - rvr_pkg::atan_turn(k);
            end else begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + rvr_pkg::atan_turn(k);
            end
            q_ff[k+1] <= q_ff[k];
            vec_ff[k+1] <= vec_ff[k];
            axis_ff[k+1] <= axis_ff[k];
         end
      end
   end

   assign xr = x_ff[N] + XW'(rvr_pkg::HALF_LSB);
   assign yr = y_ff[N] + XW'(rvr_pkg::HALF_LSB);
   assign cc = CW'(xr >>> rvr_pkg::FRAC_SHIFT);
   assign ss = CW'(yr >>> rvr_pkg::FRAC_SHIFT);

   always_comb begin
      case (q_ff[N])
         rvr_pkg::QUAD_I: begin
            c_in = cc;
            s_in = ss;
         end
         rvr_pkg::QUAD_II: begin
            c_in = -ss;
            s_in = cc;
         end
         rvr_pkg::QUAD_III: begin
            c_in = -cc;
            s_in = -ss;
         end
         default: begin
            c_in = ss;
            s_in = -cc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
         s_ff <= s_in;
         vec_o_ff <= vec_ff[N];
         axis_o_ff <= axis_ff[N];
      end
   end

   assign out_valid = vld_ff[N+1];
   assign vec_out = vec_o_ff;
   assign axis_out = axis_o_ff;
   assign cos_out = c_ff;
   assign sin_out = s_ff;
endmodule

[rtl/rvr_combine.sv]
module rvr_combine #(
   parameter int COMP_BITS = rvr_pkg::COMP_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [2:0][COMP_BITS-1:0] vec_in,
   input  logic [2:0][COMP_BITS-1:0] axis_in,
   input  logic signed [rvr_pkg::CS_W-1:0] cos_in,
   input  logic signed [rvr_pkg::CS_W-1:0] sin_in,
   output logic out_valid,
   output rvr_pkg::norm_type norm_out
);
   localparam int CB = COMP_BITS;
   localparam int CW = rvr_pkg::CS_W;
   localparam int PW = 2 * CB;
   localparam int CRW = PW + 1;
   localparam int DTW = PW + 2;
   localparam int OW = CW + 1;
   localparam int VCW = CB + CW;
   localparam int CSW = CRW + CW;
   localparam int DPW = DTW + OW;
   localparam int TW = DPW - rvr_pkg::FRAC_SHIFT;
   localparam int ATW = CB + TW;
   localparam int VSW = VCW + rvr_pkg::FRAC_SHIFT;
   localparam int M1 = (ATW > VSW) ? ATW : VSW;
   localparam int RW = ((M1 > CSW) ? M1 : CSW) + 2;
   localparam int SHW = $clog2(RW + 1);
   localparam int MW = rvr_pkg::MAG_W;

   logic [8:0] vld_ff;

   logic signed [PW-1:0] p_ff [3][3];
   logic signed [VCW-1:0] vc1_ff [3], vc2_ff [3], vc3_ff [3], vc4_ff [3], vc5_ff [3];
   logic signed [CB-1:0] a1_ff [3], a2_ff [3], a3_ff [3], a4_ff [3];
   logic signed [CW-1:0] c1_ff, s1_ff, s2_ff;
   logic signed [CRW-1:0] cr_ff [3];
   logic signed [DTW-1:0] dot_ff;
   logic signed [OW-1:0] omc_ff;
   logic signed [CSW-1:0] crs3_ff [3], crs4_ff [3], crs5_ff [3];
   logic signed [DPW-1:0] dp_ff;
   logic signed [TW-1:0] t_ff;
   logic signed [ATW-1:0] at_ff [3];
   logic [RW-1:0] mag6_ff [3], mag7_ff [3], mag8_ff [3];
   logic [2:0] neg6_ff, neg7_ff, neg8_ff;
   logic [RW-1:0] mx_ff;
   logic zero7_ff, zero8_ff;
   logic [SHW-1:0] sh_ff, sh_in;
   rvr_pkg::norm_type norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[i][j] <= $signed(axis_in[i]) * $signed(vec_in[j]);
            end
            vc1_ff[i] <= $signed(vec_in[i]) * cos_in;
            a1_ff[i] <= $signed(axis_in[i]);
         end
         c1_ff <= cos_in;
         s1_ff <= sin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff[0] <= CRW'(p_ff[1][2]) - CRW'(p_ff[2][1]);
         cr_ff[1] <= CRW'(p_ff[2][0]) - CRW'(p_ff[0][2]);
         cr_ff[2] <= CRW'(p_ff[0][1]) - CRW'(p_ff[1][0]);
         dot_ff <= DTW'(p_ff[0][0]) + DTW'(p_ff[1][1]) + DTW'(p_ff[2][2]);
         omc_ff <= OW'(rvr_pkg::UNITY) - OW'(c1_ff);
         s2_ff <= s1_ff;
         vc2_ff <= vc1_ff;
         a2_ff <= a1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            crs3_ff[i] <= cr_ff[i] * s2_ff;
         end
         dp_ff <= dot_ff * omc_ff;
         vc3_ff <= vc2_ff;
         a3_ff <= a2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= TW'((dp_ff + DPW'(rvr_pkg::HALF_LSB)) >>> rvr_pkg::FRAC_SHIFT);
         crs4_ff <= crs3_ff;
         vc4_ff <= vc3_ff;
         a4_ff <= a3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            at_ff[i] <= a4_ff[i] * t_ff;
         end
         crs5_ff <= crs4_ff;
         vc5_ff <= vc4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [RW-1:0] r;
            r = (RW'(vc5_ff[i]) <<< rvr_pkg::FRAC_SHIFT) + RW'(crs5_ff[i]) + RW'(at_ff[i]);
            neg6_ff[i] <= r[RW-1];
            mag6_ff[i] <= r[RW-1] ? RW'(-r) : RW'(r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         logic [RW-1:0] m01;
         m01 = (mag6_ff[0] > mag6_ff[1]) ? mag6_ff[0] : mag6_ff[1];
         mx_ff <= (m01 > mag6_ff[2]) ? m01 : mag6_ff[2];
         zero7_ff <= (mag6_ff[0] == '0) && (mag6_ff[1] == '0) && (mag6_ff[2] == '0);
         mag7_ff <= mag6_ff;
         neg7_ff <= neg6_ff;
      end
   end

   // shift that brings the largest magnitude below the normalizer width
   always_comb begin
      logic [SHW-1:0] len;
      len = '0;
      for (int b = 0; b < RW; b++) begin
         if (mx_ff[b]) begin
            len = SHW'(b + 1);
         end
      end
      sh_in = (len > SHW'(MW)) ? len - SHW'(MW) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff <= sh_in;
         mag8_ff <= mag7_ff;
         neg8_ff <= neg7_ff;
         zero8_ff <= zero7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            norm_ff.mag[i] <= MW'(mag8_ff[i] >> sh_ff);
         end
         norm_ff.neg <= neg8_ff;
         norm_ff.zero <= zero8_ff;
      end
   end

   assign out_valid = vld_ff[8];
   assign norm_out = norm_ff;
endmodule

[rtl/rvr_sqrt.sv]
module rvr_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  rvr_pkg::norm_type norm_in,
   output logic out_valid,
   output rvr_pkg::norm_type norm_out,
   output logic [rvr_pkg::ROOT_W-1:0] root_out
);
   localparam int MW = rvr_pkg::MAG_W;
   localparam int SW = rvr_pkg::SQ_W;
   localparam int NR = rvr_pkg::ROOT_W;
   localparam int TWD = SW + 2;

   logic [NR+1:0] vld_ff;
   logic [2*MW-1:0] sq_ff [3];
   rvr_pkg::norm_type n1_ff;
   logic [TWD-1:0] rem_ff [0:NR];
   logic [NR-1:0] root_ff [0:NR];
   rvr_pkg::norm_type pay_ff [0:NR];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NR:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= (2*MW)'(norm_in.mag[i]) * (2*MW)'(norm_in.mag[i]);
         end
         n1_ff <= norm_in;
         rem_ff[0] <= TWD'(sq_ff[0]) + TWD'(sq_ff[1]) + TWD'(sq_ff[2]);
         root_ff[0] <= '0;
         pay_ff[0] <= n1_ff;
      end
   end

   for (genvar j = 0; j < NR; j++) begin : g_root
      localparam int B = NR - 1 - j;
      logic [TWD-1:0] trial;
      assign trial = (TWD'(root_ff[j]) << (B + 1)) + (TWD'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[j] >= trial) begin
               rem_ff[j+1] <= rem_ff[j] - trial;
               root_ff[j+1] <= root_ff[j] | (NR'(1) << B);
            end else begin
               rem_ff[j+1] <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
            pay_ff[j+1] <= pay_ff[j];
         end
      end
   end

   assign out_valid = vld_ff[NR+1];
   assign norm_out = pay_ff[NR];
   assign root_out = root_ff[NR];
endmodule

[rtl/rvr_divide.sv]
module rvr_divide #(
   parameter int COMP_BITS = rvr_pkg::COMP_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  rvr_pkg::norm_type norm_in,
   input  logic [rvr_pkg::ROOT_W-1:0] root_in,
   output logic out_valid,
   output logic [2:0][COMP_BITS-1:0] rot_out,
   output logic zero_out
);
   localparam int MW = rvr_pkg::MAG_W;
   localparam int NR = rvr_pkg::ROOT_W;
   localparam int QW = rvr_pkg::QUO_W;
   localparam int NW = MW + rvr_pkg::FRAC_SHIFT + 1;

   logic [QW+1:0] vld_ff;
   logic [NW-1:0] rem_ff [0:QW][3];
   logic [QW-1:0] quo_ff [0:QW][3];
   logic [NR-1:0] m_ff [0:QW];
   logic [2:0] neg_ff [0:QW];
   logic zero_ff [0:QW];
   logic [2:0][COMP_BITS-1:0] rot_ff;
   logic zero_o_ff;
   logic [NR-1:0] m_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW:0], in_valid};
      end
   end

   assign m_in = (root_in == '0) ? NR'(1) : root_in;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (NW'(norm_in.mag[i]) << rvr_pkg::FRAC_SHIFT) + NW'(m_in >> 1);
            quo_ff[0][i] <= '0;
         end
         m_ff[0] <= m_in;
         neg_ff[0] <= norm_in.neg;
         zero_ff[0] <= norm_in.zero;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_quo
      localparam int B = QW - 1 - j;
      logic [NW-1:0] dsh;
      assign dsh = NW'(m_ff[j]) << B;
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (rem_ff[j][i] >= dsh) begin
                  rem_ff[j+1][i] <= rem_ff[j][i] - dsh;
                  quo_ff[j+1][i] <= quo_ff[j][i] | (QW'(1) << B);
               end else begin
                  rem_ff[j+1][i] <= rem_ff[j][i];
                  quo_ff[j+1][i] <= quo_ff[j][i];
               end
            end
            m_ff[j+1] <= m_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [31:0] q;
            q = 32'(quo_ff[QW][i]);
            if (zero_ff[QW]) begin
               rot_ff[i] <= '0;
            end else if (neg_ff[QW][i]) begin
               rot_ff[i] <= COMP_BITS'(-q);
            end else begin
               rot_ff[i] <= COMP_BITS'(q);
            end
         end
         zero_o_ff <= zero_ff[QW];
      end
   end

   assign out_valid = vld_ff[QW+1];
   assign rot_out = rot_ff;
   assign zero_out = zero_o_ff;
endmodule

[rtl/rodrigues_vector_rotation.sv]
// rodrigues rotation with normalization, fully pipelined
// stages in order: cordic, combine, square root with one stage per root bit,
// then divide with one stage per quotient bit
// throughput: one item per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears all valid bits; payload registers are not reset
`include "rodrigues_vector_rotation_macros.svh"
module rodrigues_vector_rotation #(
   parameter int COMP_BITS = rvr_pkg::COMP_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [COMP_BITS-1:0] req_vec_x,
   input  logic signed [COMP_BITS-1:0] req_vec_y,
   input  logic signed [COMP_BITS-1:0] req_vec_z,
   input  logic signed [COMP_BITS-1:0] req_axis_x,
   input  logic signed [COMP_BITS-1:0] req_axis_y,
   input  logic signed [COMP_BITS-1:0] req_axis_z,
   input  logic [15:0] req_turn_angle,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [COMP_BITS-1:0] rsp_rot_x,
   output logic signed [COMP_BITS-1:0] rsp_rot_y,
   output logic signed [COMP_BITS-1:0] rsp_rot_z,
   output logic rsp_zero_length
);
   logic en;
   logic [2:0][COMP_BITS-1:0] vec, axis, vec_c, axis_c, rot;
   logic signed [rvr_pkg::CS_W-1:0] cos_c, sin_c;
   logic vld_c, vld_n, vld_s;
   rvr_pkg::norm_type norm_n, norm_s;
   logic [rvr_pkg::ROOT_W-1:0] root_s;

   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = rsp_valid && rsp_stall;
   assign vec = {req_vec_z, req_vec_y, req_vec_x};
   assign axis = {req_axis_z, req_axis_y, req_axis_x};

   rvr_cordic #(.COMP_BITS(COMP_BITS)) u_cordic (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .vec_in(vec), .axis_in(axis), .angle_in(req_turn_angle),
      .out_valid(vld_c), .vec_out(vec_c), .axis_out(axis_c),
      .cos_out(cos_c), .sin_out(sin_c)
   );

   rvr_combine #(.COMP_BITS(COMP_BITS)) u_combine (
      .clock(clock), .reset(reset), .en(en), .in_valid(vld_c),
      .vec_in(vec_c), .axis_in(axis_c), .cos_in(cos_c), .sin_in(sin_c),
      .out_valid(vld_n), .norm_out(norm_n)
   );

   rvr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(vld_n),
      .norm_in(norm_n), .out_valid(vld_s), .norm_out(norm_s), .root_out(root_s)
   );

   rvr_divide #(.COMP_BITS(COMP_BITS)) u_divide (
      .clock(clock), .reset(reset), .en(en), .in_valid(vld_s),
      .norm_in(norm_s), .root_in(root_s),
      .out_valid(rsp_valid), .rot_out(rot), .zero_out(rsp_zero_length)
   );

   assign rsp_rot_x = rot[0];
   assign rsp_rot_y = rot[1];
   assign rsp_rot_z = rot[2];

   `RVR_ASSERT_IMP(a_zero_out, clock, reset, rsp_valid && rsp_zero_length, (rsp_rot_x == '0) && (rsp_rot_y == '0) && (rsp_rot_z == '0))
   `RVR_ASSERT_IMP(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall)
   `RVR_ASSERT_NXT(a_hold_out, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rot_x) && $stable(rsp_zero_length))
endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

   localparam int W = rvr_pkg::COMP_BITS_DEFAULT;
   localparam int PIPE_CYCLES = 77;

   typedef struct {
      logic signed [W-1:0] x, y, z;
      logic zl;
   } rot_type;

   localparam longint ATAN_TURN [rvr_pkg::CORDIC_STEPS] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81};

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [W-1:0] req_vec_x, req_vec_y, req_vec_z;
   logic signed [W-1:0] req_axis_x, req_axis_y, req_axis_z;
   logic [15:0] req_turn_angle;
   logic rsp_valid, rsp_stall;
   logic signed [W-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_zero_length;

   rot_type expected_rot [$];
   int errors = 0;
   bit quiet = 0;
   bit long_hold = 0;

   rodrigues_vector_rotation u_dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy, cc, ss;
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) * 256;
      for (int i = 0; i < rvr_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURN[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TURN[i];
         end
      end
      cc = (x + 8192) >>> 14;
      ss = (y + 8192) >>> 14;
      case (rvr_pkg::quad_type'(ang[15:14]))
         rvr_pkg::QUAD_I: begin c = cc; s = ss; end
         rvr_pkg::QUAD_II: begin c = -ss; s = cc; end
         rvr_pkg::QUAD_III: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic rot_type rotate_unit(input logic signed [W-1:0] vx, vy, vz, ax, ay, az,
                                           input logic [15:0] ang);
      longint v[3], a[3], cr[3], r[3];
      longint c, s, dot, t;
      longint unsigned mag[3], mx, n2, m, q;
      logic signed [W-1:0] o[3];
      int sh;
      rot_type res;
      v[0] = vx; v[1] = vy; v[2] = vz;
      a[0] = ax; a[1] = ay; a[2] = az;
      sin_cos(ang, c, s);
      cr[0] = a[1] * v[2] - a[2] * v[1];
      cr[1] = a[2] * v[0] - a[0] * v[2];
      cr[2] = a[0] * v[1] - a[1] * v[0];
      dot = a[0] * v[0] + a[1] * v[1] + a[2] * v[2];
      t = (dot * (65536 - c) + 8192) >>> 14;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         r[i] = v[i] * c * 16384 + cr[i] * s + a[i] * t;
         mag[i] = r[i] < 0 ? -r[i] : r[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         res.x = 0; res.y = 0; res.z = 0; res.zl = 1;
         return res;
      end
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      n2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] >>= sh;
         n2 += mag[i] * mag[i];
      end
      m = int_sqrt(n2);
      if (m == 0) m = 1;
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + m / 2) / m;
         o[i] = r[i] < 0 ? -W'(q) : W'(q);
      end
      res.x = o[0]; res.y = o[1]; res.z = o[2]; res.zl = 0;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic signed [W-1:0] vx, vy, vz, ax, ay, az,
                            input logic [15:0] ang, input bit no_gap = 0);
      int gap;
      req_valid <= 1;
      req_vec_x <= vx; req_vec_y <= vy; req_vec_z <= vz;
      req_axis_x <= ax; req_axis_y <= ay; req_axis_z <= az;
      req_turn_angle <= ang;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rot.push_back(rotate_unit(vx, vy, vz, ax, ay, az, ang));
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: runs of stall and go, plus a long hold on request
   initial begin
      int run, held;
      bit st;
      rsp_stall <= 0;
      run = 0; st = 0; held = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            held++;
            if (held == 300) begin
               long_hold <= 0;
               held = 0;
            end
         end else begin
            if (run == 0) begin
               st = !quiet && $urandom_range(0, 3) == 0;
               run = pick_gap() + 1;
            end
            run--;
            rsp_stall <= st;
         end
      end
   end

   always @(posedge clock) begin
      rot_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rot.size() == 0) begin
            $display("%0t: unexpected item x=%0d y=%0d z=%0d zl=%0b", $time,
                     rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_zero_length);
            errors++;
         end else begin
            e = expected_rot.pop_front();
            if (rsp_rot_x !== e.x || rsp_rot_y !== e.y || rsp_rot_z !== e.z ||
                rsp_zero_length !== e.zl) begin
               $display("%0t: mismatch expected %0d %0d %0d zl=%0b actual %0d %0d %0d zl=%0b",
                        $time, e.x, e.y, e.z, e.zl,
                        rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_zero_length);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      logic [15:0] angs[5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
      foreach (angs[i])
         send_item(16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, angs[i]);
      // zero vector
      send_item(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd12345);
      // vector along axis
      send_item(16'sd0, 16'sd0, 16'sd8192, 16'sd0, 16'sd0, 16'sd16384, 16'd5000);
      // zero axis, extremes
      send_item(16'h7fff, 16'h8000, 16'h7fff, 16'sd0, 16'sd0, 16'sd0, 16'd16384);
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd65535);
      send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd32768);
      send_item(16'h8000, 16'h7fff, 16'h0001, -16'sd16384, 16'sd16384, 16'sd0, 16'd8192);
      send_item(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'd100);
      send_item(-16'sd1, -16'sd1, -16'sd1, 16'sd9459, 16'sd9459, 16'sd9459, 16'd40000);
      send_item(16'sd4096, 16'sd4096, 16'sd0, 16'sd11585, -16'sd11585, 16'sd0, 16'd24576);
      send_item(16'hffff, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd1);
   endtask

   function automatic logic signed [W-1:0] rand_axis();
      if ($urandom_range(0, 1)) return W'($urandom());
      return W'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) quiet = $urandom_range(0, 3) == 0;
         send_item(W'($urandom()), W'($urandom()), W'($urandom()),
                   rand_axis(), rand_axis(), rand_axis(), 16'($urandom()));
      end
      quiet = 0;
   endtask

   task automatic test_backpressure();
      long_hold <= 1;
      for (int i = 0; i < 150; i++)
         send_item(W'($urandom()), W'($urandom()), W'($urandom()),
                   rand_axis(), rand_axis(), rand_axis(), 16'($urandom()), 1);
   endtask

   initial begin
      int waited;
      reset = 1;
      req_valid = 0;
      req_vec_x = 0; req_vec_y = 0; req_vec_z = 0;
      req_axis_x = 0; req_axis_y = 0; req_axis_z = 0;
      req_turn_angle = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(800);
      test_backpressure();
      test_random(800);
      req_valid <= 0;
      waited = 0;
      while (expected_rot.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * PIPE_CYCLES) @(posedge clock);
      if (errors == 0 && expected_rot.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule

[rodrigues_vector_rotation.f]
+incdir+rtl
rtl/rvr_pkg.sv
rtl/rvr_cordic.sv
rtl/rvr_combine.sv
rtl/rvr_sqrt.sv
rtl/rvr_divide.sv
rtl/rodrigues_vector_rotation.sv
bench/tb_top.sv
